// ===== hw/rtl/hvn_pkg.sv =====
// Shared types and constants for the heightmap vertex normal block.
// Used by every RTL file of the block but hvn_ram; depends on nothing.
package hvn_pkg;

   localparam int MAX_COLS_DEFAULT = 1024;
   localparam int ROW_LIMIT = 1024;
   localparam int Q_ONE = 16384;

   localparam int CFG_W = 11;
   localparam int IDX_W = 2;
   localparam int HEIGHT_W = 8;
   localparam int DIV_W = 8;
   localparam int ROW_W = 10;
   localparam int POS_W = 10;
   localparam int FACE_W = 10;
   localparam int SUM_W = 11;
   localparam int CNT_FACES_W = 3;
   localparam int MAG_W = 10;
   localparam int SQ_W = 20;
   localparam int SSQ_W = 22;
   localparam int M_W = 15;
   localparam int K2_W = 30;
   localparam int PROD_W = 52;
   localparam int BIT_W = 4;
   localparam int NX_W = 16;
   localparam int NY_W = 15;
   localparam int COMP_W = 2;

   localparam logic [IDX_W-1:0] REG_GRID_COLS = 2'd0;
   localparam logic [IDX_W-1:0] REG_GRID_ROWS = 2'd1;
   localparam logic [IDX_W-1:0] REG_HEIGHT_DIVISOR = 2'd2;

   localparam logic [CFG_W-1:0] GRID_COLS_RESET = 11'd256;
   localparam logic [CFG_W-1:0] GRID_ROWS_RESET = 11'd256;
   localparam logic [DIV_W-1:0] DIVISOR_RESET = 8'd15;

   localparam logic [COMP_W-1:0] COMP_X = 2'd0;
   localparam logic [COMP_W-1:0] COMP_Y = 2'd1;
   localparam logic [COMP_W-1:0] COMP_Z = 2'd2;

   localparam logic [BIT_W-1:0] TOP_BIT = 4'd14;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic              accept;
      logic              rd_b;
      logic              rd_c;
      logic              calc;
      logic              sum;
      logic              loadv;
      logic              sq;
      logic              ssum;
      logic              nk;
      logic              np;
      logic              nc;
      logic              load_out;
      logic              vsel;
      logic [COMP_W-1:0] comp;
      logic [BIT_W-1:0]  bit_idx;
   } cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic row_zero;
      logic two_results;
      logic out_free;
   } status_type;

endpackage

// ===== hw/rtl/hvn_if.sv =====
// Handshake channel interfaces of the heightmap vertex normal block.
// Depends on hvn_pkg for field widths.
interface hvn_req_if;
   logic                          valid;
   logic                          ready;
   logic [hvn_pkg::HEIGHT_W-1:0]  height;
   modport source (output valid, output height, input ready);
   modport sink (input valid, input height, output ready);
endinterface

interface hvn_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [hvn_pkg::POS_W-1:0]     vertex_col;
   logic [hvn_pkg::POS_W-1:0]     vertex_row;
   logic signed [hvn_pkg::NX_W-1:0] normal_x;
   logic [hvn_pkg::NY_W-1:0]      normal_y;
   logic signed [hvn_pkg::NX_W-1:0] normal_z;
   logic                          last_of_run;
   modport source (output valid, output vertex_col, output vertex_row, output normal_x,
                   output normal_y, output normal_z, output last_of_run, input ready);
   modport sink (input valid, input vertex_col, input vertex_row, input normal_x,
                 input normal_y, input normal_z, input last_of_run, output ready);
endinterface

interface hvn_csr_if;
   logic                          valid;
   logic                          ready;
   logic [hvn_pkg::IDX_W-1:0]     index;
   logic [hvn_pkg::CFG_W-1:0]     data;
   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/heightmap_vertex_normals.sv =====
// A sample of row zero is stored and yields no word; any other sample presents one
// normal word, and on the last row a second word follows it.
// Samples are taken one at a time: the next is accepted only once the previous one
// is through, which for a row other than zero includes the shared square-and-compare
// search over 15 result bits and 3 components. A stalled result channel holds the
// next word and the input.
// Reset (synchronous, active high) restores the register defaults and the raster position.
module heightmap_vertex_normals #(
   parameter int MAX_COLS = hvn_pkg::MAX_COLS_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   hvn_req_if.sink   req_if,
   hvn_rsp_if.source rsp_if,
   hvn_csr_if.sink   csr_if
);

   // The controller sequences one sample at a time; the datapath holds the two
   // line stores (heights of the row above and faces of the latest face row)
   // and a single shared multiplier chain for the normalization search.
   hvn_pkg::cmd_type    cmd;
   hvn_pkg::status_type status;
   logic                req_ready;

   assign req_if.ready = req_ready;

   hvn_ctrl u_ctrl (
      .clock(clock),
      .reset(reset),
      .req_valid(req_if.valid),
      .req_ready(req_ready),
      .status(status),
      .cmd(cmd)
   );

   // The result word sits in its own register, so the next sample may be taken
   // while the previous word still waits on the response channel.
   hvn_dp #(.MAX_COLS(MAX_COLS)) u_dp (
      .clock(clock),
      .reset(reset),
      .req_height(req_if.height),
      .csr_if(csr_if),
      .rsp_if(rsp_if),
      .cmd(cmd),
      .status(status)
   );

endmodule

// ===== hw/rtl/hvn_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module hvn_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem_ff[waddr] <= wdata;
      end
      rdata_ff <= mem_ff[raddr];
   end

   assign rdata = rdata_ff;

endmodule

// ===== hw/rtl/hvn_ctrl.sv =====
// Sequencer of the heightmap vertex normal block: steps the datapath through
// line reads, face sums and the bitwise normalization search. Uses hvn_pkg.
module hvn_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  hvn_pkg::status_type status,
   output hvn_pkg::cmd_type    cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_RD_A, ST_RD_B, ST_RD_C, ST_CALC, ST_SUM, ST_LOADV,
      ST_SQ, ST_SSUM, ST_NK, ST_NP, ST_NC, ST_OUT
   } state_type;

   state_type                    state_ff, state_in;
   logic [hvn_pkg::COMP_W-1:0]   comp_ff, comp_in;
   logic [hvn_pkg::BIT_W-1:0]    bit_ff, bit_in;
   logic                         vsel_ff, vsel_in;

   always_comb begin
      state_in = state_ff;
      comp_in = comp_ff;
      bit_in = bit_ff;
      vsel_in = vsel_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               state_in = ST_RD_A;
            end
         end
         ST_RD_A: state_in = ST_RD_B;
         ST_RD_B: state_in = ST_RD_C;
         ST_RD_C: state_in = ST_CALC;
         ST_CALC: state_in = ST_SUM;
         ST_SUM: begin
            vsel_in = 1'b0;
            state_in = status.row_zero ? ST_IDLE : ST_LOADV;
         end
         ST_LOADV: begin
            comp_in = hvn_pkg::COMP_X;
            state_in = ST_SQ;
         end
         ST_SQ: begin
            if (comp_ff == hvn_pkg::COMP_Z) begin
               comp_in = hvn_pkg::COMP_X;
               state_in = ST_SSUM;
            end else begin
               comp_in = comp_ff + 1'b1;
            end
         end
         ST_SSUM: begin
            bit_in = hvn_pkg::TOP_BIT;
            state_in = ST_NK;
         end
         ST_NK: state_in = ST_NP;
         ST_NP: state_in = ST_NC;
         ST_NC: begin
            if (bit_ff == '0) begin
               if (comp_ff == hvn_pkg::COMP_Z) begin
                  state_in = ST_OUT;
               end else begin
                  comp_in = comp_ff + 1'b1;
                  bit_in = hvn_pkg::TOP_BIT;
                  state_in = ST_NK;
               end
            end else begin
               bit_in = bit_ff - 1'b1;
               state_in = ST_NK;
            end
         end
         ST_OUT: begin
            if (status.out_free) begin
               if (!vsel_ff && status.two_results) begin
                  vsel_in = 1'b1;
                  state_in = ST_LOADV;
               end else begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         comp_ff <= hvn_pkg::COMP_X;
         bit_ff <= '0;
         vsel_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         comp_ff <= comp_in;
         bit_ff <= bit_in;
         vsel_ff <= vsel_in;
      end
   end

   assign req_ready = (state_ff == ST_IDLE);

   always_comb begin
      cmd = '0;
      cmd.accept = (state_ff == ST_IDLE) && req_valid;
      cmd.rd_b = (state_ff == ST_RD_B);
      cmd.rd_c = (state_ff == ST_RD_C);
      cmd.calc = (state_ff == ST_CALC);
      cmd.sum = (state_ff == ST_SUM);
      cmd.loadv = (state_ff == ST_LOADV);
      cmd.sq = (state_ff == ST_SQ);
      cmd.ssum = (state_ff == ST_SSUM);
      cmd.nk = (state_ff == ST_NK);
      cmd.np = (state_ff == ST_NP);
      cmd.nc = (state_ff == ST_NC);
      cmd.load_out = (state_ff == ST_OUT) && status.out_free;
      cmd.vsel = vsel_ff;
      cmd.comp = comp_ff;
      cmd.bit_idx = bit_ff;
   end

endmodule

// ===== hw/rtl/hvn_dp.sv =====
// Datapath of the heightmap vertex normal block: configuration registers,
// line stores, face sums, normalization arithmetic and the result register.
// Uses hvn_pkg, hvn_if and hvn_ram.
module hvn_dp #(
   parameter int MAX_COLS = hvn_pkg::MAX_COLS_DEFAULT
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [hvn_pkg::HEIGHT_W-1:0]  req_height,
   hvn_csr_if.sink                       csr_if,
   hvn_rsp_if.source                     rsp_if,
   input  hvn_pkg::cmd_type              cmd,
   output hvn_pkg::status_type           status
);

   localparam int CNT_W = $clog2(MAX_COLS);
   localparam int LIM_W = (CNT_W + 1 > hvn_pkg::CFG_W) ? CNT_W + 1 : hvn_pkg::CFG_W;
   localparam logic [LIM_W-1:0] COLS_MAX = LIM_W'(MAX_COLS);
   localparam logic [LIM_W-1:0] COLS_MIN = LIM_W'(2);
   localparam logic [hvn_pkg::CFG_W-1:0] ROWS_MAX = 11'(hvn_pkg::ROW_LIMIT);
   localparam logic [hvn_pkg::CFG_W-1:0] ROWS_MIN = 11'd2;
   localparam int FP_W = 2 * hvn_pkg::FACE_W;

   // Configuration registers.
   logic [hvn_pkg::CFG_W-1:0] grid_cols_ff, grid_rows_ff;
   logic [hvn_pkg::DIV_W-1:0] divisor_ff;
   logic                      csr_write, geom_write;

   assign csr_if.ready = 1'b1;
   assign csr_write = csr_if.valid;
   assign geom_write = csr_write && (csr_if.index == hvn_pkg::REG_GRID_COLS ||
                                     csr_if.index == hvn_pkg::REG_GRID_ROWS);

   always_ff @(posedge clock) begin
      if (reset) begin
         grid_cols_ff <= hvn_pkg::GRID_COLS_RESET;
         grid_rows_ff <= hvn_pkg::GRID_ROWS_RESET;
         divisor_ff <= hvn_pkg::DIVISOR_RESET;
      end else if (csr_write) begin
         case (csr_if.index)
            hvn_pkg::REG_GRID_COLS: grid_cols_ff <= csr_if.data;
            hvn_pkg::REG_GRID_ROWS: grid_rows_ff <= csr_if.data;
            hvn_pkg::REG_HEIGHT_DIVISOR: divisor_ff <= csr_if.data[hvn_pkg::DIV_W-1:0];
            default: ;
         endcase
      end
   end

   // Clamped geometry.
   logic [LIM_W-1:0]          cols_ext, cols_lim;
   logic [hvn_pkg::CFG_W-1:0] rows_lim;
   logic [hvn_pkg::DIV_W-1:0] div_eff;

   assign cols_ext = LIM_W'(grid_cols_ff);
   assign cols_lim = (cols_ext < COLS_MIN) ? COLS_MIN :
                     ((cols_ext > COLS_MAX) ? COLS_MAX : cols_ext);
   assign rows_lim = (grid_rows_ff < ROWS_MIN) ? ROWS_MIN :
                     ((grid_rows_ff > ROWS_MAX) ? ROWS_MAX : grid_rows_ff);
   assign div_eff = (divisor_ff == '0) ? hvn_pkg::DIV_W'(1) : divisor_ff;

   // Raster position.
   logic [CNT_W-1:0]          col_cnt_ff, c_ff, c_wrap;
   logic [hvn_pkg::ROW_W-1:0] row_cnt_ff, r_ff, r_wrap;
   logic [hvn_pkg::HEIGHT_W-1:0] h_in_ff;
   logic                      inner, c_nz, r_ge2, last_col, last_row;

   assign c_wrap = (LIM_W'(col_cnt_ff) >= cols_lim) ? '0 : col_cnt_ff;
   assign r_wrap = (11'(row_cnt_ff) >= rows_lim) ? '0 : row_cnt_ff;
   assign inner = (LIM_W'(c_ff) + LIM_W'(1)) < cols_lim;
   assign c_nz = (c_ff != '0);
   assign r_ge2 = (r_ff >= hvn_pkg::ROW_W'(2));
   assign last_col = !inner;
   assign last_row = (11'(r_ff) + 11'd1) >= rows_lim;

   always_ff @(posedge clock) begin
      if (reset) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (geom_write) begin
         col_cnt_ff <= '0;
         row_cnt_ff <= '0;
      end else if (cmd.sum) begin
         if (last_col) begin
            col_cnt_ff <= '0;
            row_cnt_ff <= last_row ? '0 : r_ff + 1'b1;
         end else begin
            col_cnt_ff <= c_ff + 1'b1;
            row_cnt_ff <= r_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.accept) begin
         c_ff <= c_wrap;
         r_ff <= r_wrap;
         h_in_ff <= req_height;
      end
   end

   // Line stores.
   logic [CNT_W-1:0]            h_raddr;
   logic [hvn_pkg::HEIGHT_W-1:0] h_rdata;
   logic [FP_W-1:0]             f_rdata, fresh;
   logic                        f_we;

   assign h_raddr = cmd.rd_b ? c_ff + 1'b1 : c_ff;
   assign f_we = cmd.sum && !status.row_zero && inner;

   hvn_ram #(.WIDTH(hvn_pkg::HEIGHT_W), .DEPTH(MAX_COLS)) u_height_line (
      .clock(clock), .we(cmd.sum), .waddr(c_ff), .wdata(h_in_ff),
      .raddr(h_raddr), .rdata(h_rdata)
   );

   hvn_ram #(.WIDTH(FP_W), .DEPTH(MAX_COLS)) u_face_line (
      .clock(clock), .we(f_we), .waddr(c_ff), .wdata(fresh),
      .raddr(c_ff), .rdata(f_rdata)
   );

   // Faces and sums.
   logic [hvn_pkg::HEIGHT_W-1:0]       h00_ff, h10_ff;
   logic [FP_W-1:0]                    old_ff, prev_face_ff, left_ff;
   logic signed [hvn_pkg::FACE_W-1:0]  fx_ff, fz_ff;
   logic signed [hvn_pkg::SUM_W-1:0]   sx1, sz1, sx2, sz2;
   logic [hvn_pkg::CNT_FACES_W-1:0]    cnt1, cnt2;
   logic signed [hvn_pkg::SUM_W-1:0]   sx1_ff, sz1_ff, sx2_ff, sz2_ff;
   logic [hvn_pkg::CNT_FACES_W-1:0]    cnt1_ff, cnt2_ff;

   assign fresh = {fz_ff, fx_ff};

   function automatic logic signed [hvn_pkg::SUM_W-1:0] fpart(input logic [FP_W-1:0] f,
                                                             input logic hi, input logic en);
      logic signed [hvn_pkg::FACE_W-1:0] v;
      v = hi ? f[FP_W-1:hvn_pkg::FACE_W] : f[hvn_pkg::FACE_W-1:0];
      return en ? hvn_pkg::SUM_W'(v) : '0;
   endfunction

   always_comb begin
      sx2 = fpart(left_ff, 1'b0, c_nz) + fpart(fresh, 1'b0, inner);
      sz2 = fpart(left_ff, 1'b1, c_nz) + fpart(fresh, 1'b1, inner);
      cnt2 = hvn_pkg::CNT_FACES_W'(c_nz) + hvn_pkg::CNT_FACES_W'(inner);
      sx1 = sx2 + fpart(prev_face_ff, 1'b0, c_nz && r_ge2) + fpart(old_ff, 1'b0, inner && r_ge2);
      sz1 = sz2 + fpart(prev_face_ff, 1'b1, c_nz && r_ge2) + fpart(old_ff, 1'b1, inner && r_ge2);
      cnt1 = cnt2 + hvn_pkg::CNT_FACES_W'(c_nz && r_ge2) +
             hvn_pkg::CNT_FACES_W'(inner && r_ge2);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_face_ff <= '0;
         left_ff <= '0;
      end else if (f_we) begin
         prev_face_ff <= old_ff;
         left_ff <= fresh;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd_b) begin
         h00_ff <= h_rdata;
         old_ff <= f_rdata;
      end
      if (cmd.rd_c) begin
         h10_ff <= h_rdata;
      end
      if (cmd.calc) begin
         fx_ff <= hvn_pkg::FACE_W'(h00_ff) - hvn_pkg::FACE_W'(h10_ff);
         fz_ff <= hvn_pkg::FACE_W'(h00_ff) - hvn_pkg::FACE_W'(h_in_ff);
      end
      if (cmd.sum) begin
         sx1_ff <= sx1;
         sz1_ff <= sz1;
         cnt1_ff <= cnt1;
         sx2_ff <= sx2;
         sz2_ff <= sz2;
         cnt2_ff <= cnt2;
      end
   end

   // Normalization: the largest m with (2m-1)^2 * s <= a^2 * 2^30, one bit per pass.
   logic [hvn_pkg::MAG_W-1:0]   mag_ff [3];
   logic                        neg_x_ff, neg_z_ff;
   logic [hvn_pkg::SQ_W-1:0]    sq_ff [3];
   logic [hvn_pkg::SSQ_W-1:0]   s_ff;
   logic [hvn_pkg::M_W-1:0]     m_ff [3];
   logic [hvn_pkg::M_W-1:0]     cand, cand_ff, k_val;
   logic [hvn_pkg::K2_W-1:0]    k2_ff;
   logic [hvn_pkg::PROD_W-1:0]  prod_ff, target;
   logic signed [hvn_pkg::SUM_W-1:0] sx_sel, sz_sel;
   logic [hvn_pkg::CNT_FACES_W-1:0]  cnt_sel;
   logic [hvn_pkg::SUM_W-1:0]   sy_wide, ax, az;

   assign sx_sel = cmd.vsel ? sx2_ff : sx1_ff;
   assign sz_sel = cmd.vsel ? sz2_ff : sz1_ff;
   assign cnt_sel = cmd.vsel ? cnt2_ff : cnt1_ff;
   assign sy_wide = hvn_pkg::SUM_W'(cnt_sel * div_eff);
   assign ax = sx_sel[hvn_pkg::SUM_W-1] ? -sx_sel : sx_sel;
   assign az = sz_sel[hvn_pkg::SUM_W-1] ? -sz_sel : sz_sel;
   assign cand = m_ff[cmd.comp] | (hvn_pkg::M_W'(1) << cmd.bit_idx);
   assign k_val = {cand[hvn_pkg::M_W-2:0], 1'b0} - 1'b1;
   assign target = {2'b00, sq_ff[cmd.comp], 30'b0};

   always_ff @(posedge clock) begin
      if (cmd.loadv) begin
         mag_ff[hvn_pkg::COMP_X] <= ax[hvn_pkg::MAG_W-1:0];
         mag_ff[hvn_pkg::COMP_Y] <= sy_wide[hvn_pkg::MAG_W-1:0];
         mag_ff[hvn_pkg::COMP_Z] <= az[hvn_pkg::MAG_W-1:0];
         neg_x_ff <= sx_sel[hvn_pkg::SUM_W-1];
         neg_z_ff <= sz_sel[hvn_pkg::SUM_W-1];
         m_ff[hvn_pkg::COMP_X] <= '0;
         m_ff[hvn_pkg::COMP_Y] <= '0;
         m_ff[hvn_pkg::COMP_Z] <= '0;
      end
      if (cmd.sq) begin
         sq_ff[cmd.comp] <= mag_ff[cmd.comp] * mag_ff[cmd.comp];
      end
      if (cmd.ssum) begin
         s_ff <= hvn_pkg::SSQ_W'(sq_ff[hvn_pkg::COMP_X]) + hvn_pkg::SSQ_W'(sq_ff[hvn_pkg::COMP_Y])
                 + hvn_pkg::SSQ_W'(sq_ff[hvn_pkg::COMP_Z]);
      end
      if (cmd.nk) begin
         cand_ff <= cand;
         k2_ff <= k_val * k_val;
      end
      if (cmd.np) begin
         prod_ff <= k2_ff * s_ff;
      end
      if (cmd.nc && cand_ff <= hvn_pkg::M_W'(hvn_pkg::Q_ONE) && prod_ff <= target) begin
         m_ff[cmd.comp] <= cand_ff;
      end
   end

   // Result register.
   logic                           rsp_valid_ff;
   logic [hvn_pkg::POS_W-1:0]      col_ff, row_ff;
   logic signed [hvn_pkg::NX_W-1:0] nx_ff, nz_ff;
   logic [hvn_pkg::NY_W-1:0]       ny_ff;
   logic                           last_ff;
   logic [31:0]                    c_wide;
   logic [hvn_pkg::NX_W-1:0]       mx_ext, mz_ext;

   assign c_wide = 32'(c_ff);
   assign mx_ext = hvn_pkg::NX_W'(m_ff[hvn_pkg::COMP_X]);
   assign mz_ext = hvn_pkg::NX_W'(m_ff[hvn_pkg::COMP_Z]);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.load_out) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_if.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load_out) begin
         col_ff <= c_wide[hvn_pkg::POS_W-1:0];
         row_ff <= cmd.vsel ? r_ff : r_ff - 1'b1;
         nx_ff <= neg_x_ff ? -mx_ext : mx_ext;
         ny_ff <= m_ff[hvn_pkg::COMP_Y];
         nz_ff <= neg_z_ff ? -mz_ext : mz_ext;
         last_ff <= cmd.vsel || !last_row;
      end
   end

   assign rsp_if.valid = rsp_valid_ff;
   assign rsp_if.vertex_col = col_ff;
   assign rsp_if.vertex_row = row_ff;
   assign rsp_if.normal_x = nx_ff;
   assign rsp_if.normal_y = ny_ff;
   assign rsp_if.normal_z = nz_ff;
   assign rsp_if.last_of_run = last_ff;

   assign status.row_zero = (r_ff == '0);
   assign status.two_results = last_row;
   assign status.out_free = !rsp_valid_ff || rsp_if.ready;

endmodule

// ===== verif/heightmap_vertex_normals_test.sv =====
`timescale 1ns / 100ps
// Self-checking testbench of heightmap_vertex_normals: height streams, expected normal words.
// Depends on hvn_pkg and the channel interfaces in hvn_if.sv.
module heightmap_vertex_normals_test;

   // One expected normal word, laid out as the result channel carries it.
   typedef struct {
      logic [hvn_pkg::POS_W-1:0] col;
      logic [hvn_pkg::POS_W-1:0] row;
      logic [hvn_pkg::NX_W-1:0]  nx;
      logic [hvn_pkg::NY_W-1:0]  ny;
      logic [hvn_pkg::NX_W-1:0]  nz;
      logic                      last;
   } normal_word_type;

   localparam int IDLE_TAIL = 400;     // Cycles past the last word before a register write.
   localparam int STALL_LIMIT = 6000;  // Cycles without any accepted word before giving up.

   logic clock = 1'b0;
   logic reset = 1'b1;

   hvn_req_if req ();
   hvn_rsp_if rsp ();
   hvn_csr_if csr ();

   heightmap_vertex_normals dut (
      .clock  (clock),
      .reset  (reset),
      .req_if (req),
      .rsp_if (rsp),
      .csr_if (csr)
   );

   always #5 clock = ~clock;

   // Shadow of the block's registers and raster state.
   int unsigned grid_cols_q;
   int unsigned grid_rows_q;
   int unsigned divisor_q;
   logic [7:0] heights_above [hvn_pkg::MAX_COLS_DEFAULT];
   logic signed [9:0] face_x_row [hvn_pkg::MAX_COLS_DEFAULT];
   logic signed [9:0] face_z_row [hvn_pkg::MAX_COLS_DEFAULT];
   logic signed [9:0] prev_fx, prev_fz;
   int unsigned next_col, next_row;

   normal_word_type pending_normals[$];
   int errors = 0;
   int idle_cycles = 0;
   int sent_items = 0;

   initial begin
      req.valid = 1'b0;
      req.height = '0;
      csr.valid = 1'b0;
      csr.index = '0;
      csr.data = '0;
      rsp.ready = 1'b0;
   end

   // Rounded Q1.14 magnitude of a / sqrt(s), found by an exact integer search.
   function automatic int unsigned unit_scale(int unsigned a, longint unsigned s);
      longint unsigned t, target, k;
      int unsigned lo, hi, mid;
      t = 64'd32768 * a;
      target = t * t;
      lo = 0;
      hi = hvn_pkg::Q_ONE;
      while (lo < hi) begin
         mid = (lo + hi + 1) / 2;
         k = 2 * longint'(mid) - 1;
         if (k * k * s <= target) lo = mid;
         else hi = mid - 1;
      end
      return lo;
   endfunction

   function automatic logic [hvn_pkg::NX_W-1:0] signed_q(int v, longint unsigned s);
      int unsigned m;
      m = unit_scale(v < 0 ? -v : v, s);
      return v < 0 ? hvn_pkg::NX_W'(-int'(m)) : hvn_pkg::NX_W'(m);
   endfunction

   function automatic normal_word_type vertex_normal(int unsigned c, int unsigned r,
                                                     int sx, int sz, int unsigned cnt);
      normal_word_type w;
      longint unsigned s;
      int unsigned sy;
      sy = cnt * (divisor_q == 0 ? 1 : divisor_q);
      s = longint'(sx * sx) + longint'(sy) * sy + longint'(sz * sz);
      w.col = c[hvn_pkg::POS_W-1:0];
      w.row = r[hvn_pkg::POS_W-1:0];
      w.nx = signed_q(sx, s);
      w.ny = hvn_pkg::NY_W'(unit_scale(sy, s));
      w.nz = signed_q(sz, s);
      w.last = 1'b0;
      return w;
   endfunction

   // Advance the shadow raster by one accepted height and queue the words it causes.
   task automatic predict_normals(logic [7:0] h);
      int unsigned cols, rows, c, r, cnt;
      int sx, sz, fx, fz;
      logic signed [9:0] old_x, old_z, left_x, left_z, new_x, new_z;
      bit inner;
      normal_word_type w0, w1;
      cols = grid_cols_q < 2 ? 2 : (grid_cols_q > hvn_pkg::MAX_COLS_DEFAULT ?
                                    hvn_pkg::MAX_COLS_DEFAULT : grid_cols_q);
      rows = grid_rows_q < 2 ? 2 : (grid_rows_q > hvn_pkg::ROW_LIMIT ?
                                    hvn_pkg::ROW_LIMIT : grid_rows_q);
      c = next_col >= cols ? 0 : next_col;
      r = next_row >= rows ? 0 : next_row;
      if (r >= 1) begin
         inner = c + 1 < cols;
         old_x = face_x_row[c];
         old_z = face_z_row[c];
         left_x = c >= 1 ? face_x_row[c-1] : '0;
         left_z = c >= 1 ? face_z_row[c-1] : '0;
         new_x = '0;
         new_z = '0;
         if (inner) begin
            fx = int'(heights_above[c]) - int'(heights_above[c+1]);
            fz = int'(heights_above[c]) - int'(h);
            new_x = fx[9:0];
            new_z = fz[9:0];
         end
         // Vertex of the row above: up to four faces around it.
         sx = 0; sz = 0; cnt = 0;
         if (c >= 1 && r >= 2) begin sx += prev_fx; sz += prev_fz; cnt++; end
         if (inner && r >= 2) begin sx += old_x; sz += old_z; cnt++; end
         if (c >= 1) begin sx += left_x; sz += left_z; cnt++; end
         if (inner) begin sx += new_x; sz += new_z; cnt++; end
         w0 = vertex_normal(c, r - 1, sx, sz, cnt);
         if (r + 1 == rows) begin
            // On the last row the current vertex is complete as well.
            sx = 0; sz = 0; cnt = 0;
            if (c >= 1) begin sx += left_x; sz += left_z; cnt++; end
            if (inner) begin sx += new_x; sz += new_z; cnt++; end
            w1 = vertex_normal(c, r, sx, sz, cnt);
            w1.last = 1'b1;
            pending_normals = {pending_normals, w0, w1};
         end else begin
            w0.last = 1'b1;
            pending_normals = {pending_normals, w0};
         end
         if (inner) begin
            prev_fx = old_x;
            prev_fz = old_z;
            face_x_row[c] = new_x;
            face_z_row[c] = new_z;
         end
      end
      heights_above[c] = h;
      c++;
      if (c >= cols) begin
         c = 0;
         r++;
         if (r >= rows) r = 0;
      end
      next_col = c;
      next_row = r;
   endtask

   function automatic int gap_len();
      int p;
      p = $urandom_range(0, 99);
      if (p < 45) return 0;
      if (p < 90) return $urandom_range(1, 4);
      return $urandom_range(10, 200);
   endfunction

   // Send one height word; called and returning at a falling edge.
   task automatic send_height(logic [7:0] h);
      int gap;
      gap = gap_len();
      if (gap > 0) begin
         req.valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req.valid <= 1'b1;
      req.height <= h;
      do @(posedge clock); while (!req.ready);
      predict_normals(h);
      sent_items++;
      @(negedge clock);
   endtask

   // Wait until every expected normal has arrived and the block has settled.
   task automatic drain();
      req.valid <= 1'b0;
      while (pending_normals.size() != 0) @(negedge clock);
      repeat (IDLE_TAIL) @(negedge clock);
   endtask

   task automatic write_reg(logic [hvn_pkg::IDX_W-1:0] idx, int unsigned value);
      csr.valid <= 1'b1;
      csr.index <= idx;
      csr.data <= value[hvn_pkg::CFG_W-1:0];
      do @(posedge clock); while (!csr.ready);
      case (idx)
         hvn_pkg::REG_GRID_COLS: begin
            grid_cols_q = value & 11'h7FF;
            next_col = 0;
            next_row = 0;
         end
         hvn_pkg::REG_GRID_ROWS: begin
            grid_rows_q = value & 11'h7FF;
            next_col = 0;
            next_row = 0;
         end
         hvn_pkg::REG_HEIGHT_DIVISOR: divisor_q = value & 8'hFF;
         default: ;
      endcase
      @(negedge clock);
      csr.valid <= 1'b0;
      @(negedge clock);
   endtask

   task automatic set_geometry(int unsigned cols, int unsigned rows, int unsigned div);
      write_reg(hvn_pkg::REG_GRID_COLS, cols);
      write_reg(hvn_pkg::REG_GRID_ROWS, rows);
      write_reg(hvn_pkg::REG_HEIGHT_DIVISOR, div);
   endtask

   task automatic report_mismatch(string what, longint got, longint want);
      $display("mismatch at %0t: %s got %0h expected %0h", $realtime, what, got, want);
      errors++;
   endtask

   // Result checker: every accepted normal word against the oldest expectation.
   always @(posedge clock) begin
      normal_word_type w;
      if (!reset && rsp.valid && rsp.ready) begin
         if (pending_normals.size() == 0) begin
            report_mismatch("unexpected word, col", rsp.vertex_col, 0);
         end else begin
            w = pending_normals.pop_front();
            if (rsp.vertex_col !== w.col) report_mismatch("vertex_col", rsp.vertex_col, w.col);
            if (rsp.vertex_row !== w.row) report_mismatch("vertex_row", rsp.vertex_row, w.row);
            if (rsp.normal_x !== w.nx) report_mismatch("normal_x", rsp.normal_x, w.nx);
            if (rsp.normal_y !== w.ny) report_mismatch("normal_y", rsp.normal_y, w.ny);
            if (rsp.normal_z !== w.nz) report_mismatch("normal_z", rsp.normal_z, w.nz);
            if (rsp.last_of_run !== w.last)
               report_mismatch("last_of_run", rsp.last_of_run, w.last);
         end
      end
   end

   // Result back-pressure: runs of ready broken by stalls, mostly short.
   initial begin
      int n;
      @(negedge clock);
      forever begin
         n = gap_len();
         if (n > 0) begin
            rsp.ready <= 1'b0;
            repeat (n) @(negedge clock);
         end
         rsp.ready <= 1'b1;
         repeat ($urandom_range(1, 60)) @(negedge clock);
      end
   end

   // Watchdog on cycles in which no channel moves a word.
   always @(posedge clock) begin
      if ((req.valid && req.ready) || (rsp.valid && rsp.ready) || (csr.valid && csr.ready))
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= STALL_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Small frames with heights at both extremes, including a frame wrap.
   task automatic test_directed();
      logic [7:0] pattern [12] = '{8'd0, 8'd255, 8'd0, 8'd255, 8'd0, 8'd0,
                                   8'd255, 8'd255, 8'd128, 8'd1, 8'd254, 8'd127};
      set_geometry(2, 3, 1);
      foreach (pattern[i]) send_height(pattern[i]);
      drain();
      // Register index three does not exist; out-of-range geometry is clamped.
      write_reg(2'd3, 11'h7FF);
      set_geometry(3, 0, 0);
      for (int i = 0; i < 12; i++) send_height(i[0] ? 8'd255 : 8'd0);
      drain();
   endtask

   task automatic test_divisor_extremes();
      set_geometry(4, 3, 255);
      for (int i = 0; i < 12; i++) send_height($urandom_range(0, 255));
      drain();
      // A divisor write alone does not restart the frame.
      write_reg(hvn_pkg::REG_HEIGHT_DIVISOR, 1);
      for (int i = 0; i < 12; i++) send_height($urandom_range(0, 255));
      drain();
   endtask

   // The widest row, clamped from an oversized write: a full first row and the
   // start of the second; the next geometry write restarts the frame.
   task automatic test_wide_row();
      set_geometry(2047, 2, 15);
      for (int i = 0; i < hvn_pkg::MAX_COLS_DEFAULT + 128; i++)
         send_height($urandom_range(0, 255));
      drain();
   endtask

   // The tallest frame, entered partway; the geometry write then restarts it.
   task automatic test_tall_partial();
      set_geometry(0, 1024, 40);
      for (int i = 0; i < 60; i++) send_height($urandom_range(0, 255));
      drain();
      write_reg(hvn_pkg::REG_GRID_ROWS, 1025);
      for (int i = 0; i < 20; i++) send_height($urandom_range(0, 255));
      drain();
   endtask

   // Random geometry, mostly whole frames, some cut short by the next write or run on past the frame end.
   task automatic test_random();
      int unsigned cols, rows, n, start;
      start = sent_items;
      while (sent_items - start < 500) begin
         cols = $urandom_range(0, 99) < 90 ? $urandom_range(2, 12) : $urandom_range(0, 40);
         rows = $urandom_range(0, 99) < 90 ? $urandom_range(2, 8) : $urandom_range(0, 12);
         set_geometry(cols, rows, $urandom_range(0, 255));
         n = (cols < 2 ? 2 : cols) * (rows < 2 ? 2 : rows);
         if ($urandom_range(0, 3) == 0) n = $urandom_range(1, 2 * n);
         for (int i = 0; i < n; i++) send_height($urandom_range(0, 255));
         drain();
         if ($urandom_range(0, 3) == 0) begin
            write_reg(hvn_pkg::REG_HEIGHT_DIVISOR, $urandom_range(0, 255));
            n = $urandom_range(1, 10);
            for (int i = 0; i < n; i++) send_height($urandom_range(0, 255));
            drain();
         end
      end
   endtask

   initial begin
      grid_cols_q = hvn_pkg::GRID_COLS_RESET;
      grid_rows_q = hvn_pkg::GRID_ROWS_RESET;
      divisor_q = hvn_pkg::DIVISOR_RESET;
      next_col = 0;
      next_row = 0;
      prev_fx = '0;
      prev_fz = '0;
      foreach (heights_above[i]) begin
         heights_above[i] = '0;
         face_x_row[i] = '0;
         face_z_row[i] = '0;
      end
      repeat (9) @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);
      test_directed();
      test_divisor_extremes();
      test_tall_partial();
      test_wide_row();
      test_random();
      drain();
      if (errors == 0 && pending_normals.size() == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
